### hw/rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg: shared types for the tick-timed 1-Wire bus master
// Item structs, command and phase codes, configuration register indexes.
// ----------------------------------------------------------------------------
package owbm_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SIZE_8  = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_32 = 2'd2
  } size_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_WAIT   = 4'd2,
    PH_RST_SETTLE = 4'd3,
    PH_W_LOW      = 4'd4,
    PH_W_DATA     = 4'd5,
    PH_W_REC      = 4'd6,
    PH_R_LOW      = 4'd7,
    PH_R_WAIT     = 4'd8,
    PH_R_REST     = 4'd9
  } phase_e;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned TickW    = 16;
  localparam int unsigned BitCntW  = 6;
  localparam int unsigned WordW    = 32;

  typedef enum logic [RegIdxW-1:0] {
    REG_RESET_LOW    = 3'd0,
    REG_RESET_SAMPLE = 3'd1,
    REG_RESET_SETTLE = 3'd2,
    REG_WRITE_LOW    = 3'd3,
    REG_WRITE_DATA   = 3'd4,
    REG_READ_LOW     = 3'd5,
    REG_READ_SAMPLE  = 3'd6,
    REG_READ_REST    = 3'd7
  } reg_idx_e;

  localparam logic [TickW-1:0] RstLowReset    = 16'd480;
  localparam logic [TickW-1:0] RstSampleReset = 16'd70;
  localparam logic [TickW-1:0] RstSettleReset = 16'd410;
  localparam logic [TickW-1:0] WrLowReset     = 16'd6;
  localparam logic [TickW-1:0] WrDataReset    = 16'd54;
  localparam logic [TickW-1:0] RdLowReset     = 16'd6;
  localparam logic [TickW-1:0] RdSampleReset  = 16'd9;
  localparam logic [TickW-1:0] RdRestReset    = 16'd55;

  typedef struct packed {
    logic [1:0]       action;
    logic [1:0]       transfer_size;
    logic [WordW-1:0] write_data;
    logic             line_level;
  } in_item_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic             presence_level;
    logic [WordW-1:0] read_data;
  } out_item_t;

endpackage

### hw/rtl/one_wire_bus_master_top.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_top: tick-timed 1-Wire bus master
// Result: an accepted item's result item is registered in the output register
//   in the cycle after acceptance; every item (command or tick) yields exactly one result item.
// Throughput: one item per cycle unless the output register is held by out_stall_i;
//   the slot sequencer advances its tick count by one per tick item, and the output
//   register lets a new item in while the previous result is being taken.
// Reset: rst_ni async active low; sequencer idle, presence sample high,
//   timing registers back to their defaults, output register empty.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top #(
  parameter int unsigned RECOVERY_TICKS = 10,  // 1..65535
  parameter int unsigned MAX_BITS       = 32   // 8..64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // command / tick channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  owbm_pkg::in_item_t                    in_item_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output owbm_pkg::out_item_t                   out_item_o,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [owbm_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [owbm_pkg::TickW-1:0]            cfg_data_i
);

  localparam int unsigned TickW   = owbm_pkg::TickW;
  localparam int unsigned BitCntW = owbm_pkg::BitCntW;
  localparam int unsigned WordW   = owbm_pkg::WordW;

  // Recovery length, truncated to the tick counter width, never below one.
  localparam logic [TickW-1:0] RecTicksRaw = TickW'(RECOVERY_TICKS);
  localparam logic [TickW-1:0] RecTicks    = (RecTicksRaw == '0) ? TickW'(1) : RecTicksRaw;
  localparam logic [6:0]       MaxBits     = 7'(MAX_BITS);

  // --------------------------------------------------------------------------
  // Timing registers
  // --------------------------------------------------------------------------
  logic [TickW-1:0] cfg_q [owbm_pkg::NumRegs];
  logic             cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[owbm_pkg::REG_RESET_LOW]    <= owbm_pkg::RstLowReset;
      cfg_q[owbm_pkg::REG_RESET_SAMPLE] <= owbm_pkg::RstSampleReset;
      cfg_q[owbm_pkg::REG_RESET_SETTLE] <= owbm_pkg::RstSettleReset;
      cfg_q[owbm_pkg::REG_WRITE_LOW]    <= owbm_pkg::WrLowReset;
      cfg_q[owbm_pkg::REG_WRITE_DATA]   <= owbm_pkg::WrDataReset;
      cfg_q[owbm_pkg::REG_READ_LOW]     <= owbm_pkg::RdLowReset;
      cfg_q[owbm_pkg::REG_READ_SAMPLE]  <= owbm_pkg::RdSampleReset;
      cfg_q[owbm_pkg::REG_READ_REST]    <= owbm_pkg::RdRestReset;
    end else if (cfg_fire && !cfg_index_i[owbm_pkg::CfgIdxW-1]) begin
      // indexes 8..15 are outside the register list and dropped
      cfg_q[cfg_index_i[owbm_pkg::CfgIdxW-2:0]] <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  owbm_pkg::phase_e   phase_q, phase_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic [BitCntW-1:0] bits_left_q, bits_left_d;
  logic [BitCntW-1:0] bit_pos_q, bit_pos_d;
  logic [WordW-1:0]   shift_q, shift_d;
  logic               is_read_q, is_read_d;
  logic               presence_q, presence_d;

  logic               in_fire;
  logic               done;
  logic [TickW-1:0]   phase_len;
  logic [TickW:0]     tick_inc;
  logic [BitCntW-1:0] bits_dec;
  logic [BitCntW-1:0] size_bits;
  logic [6:0]         size_raw;

  assign in_fire = in_valid_i && !in_stall_o;

  // Bits per transfer; the unused size code acts as 32.
  always_comb begin
    case (in_item_i.transfer_size)
      owbm_pkg::SIZE_8:  size_raw = 7'd8;
      owbm_pkg::SIZE_16: size_raw = 7'd16;
      default:           size_raw = 7'd32;
    endcase
    size_bits = (size_raw > MaxBits) ? MaxBits[BitCntW-1:0] : size_raw[BitCntW-1:0];
  end

  // Length of the current phase; a zero register counts as one tick.
  always_comb begin
    unique case (phase_q)
      owbm_pkg::PH_RST_LOW:    phase_len = cfg_q[owbm_pkg::REG_RESET_LOW];
      owbm_pkg::PH_RST_WAIT:   phase_len = cfg_q[owbm_pkg::REG_RESET_SAMPLE];
      owbm_pkg::PH_RST_SETTLE: phase_len = cfg_q[owbm_pkg::REG_RESET_SETTLE];
      owbm_pkg::PH_W_LOW:      phase_len = cfg_q[owbm_pkg::REG_WRITE_LOW];
      owbm_pkg::PH_W_DATA:     phase_len = cfg_q[owbm_pkg::REG_WRITE_DATA];
      owbm_pkg::PH_W_REC:      phase_len = RecTicks;
      owbm_pkg::PH_R_LOW:      phase_len = cfg_q[owbm_pkg::REG_READ_LOW];
      owbm_pkg::PH_R_WAIT:     phase_len = cfg_q[owbm_pkg::REG_READ_SAMPLE];
      owbm_pkg::PH_R_REST:     phase_len = cfg_q[owbm_pkg::REG_READ_REST];
      default:                 phase_len = TickW'(1);
    endcase
    if (phase_len == '0) begin
      phase_len = TickW'(1);
    end
  end

  assign tick_inc = {1'b0, tick_q} + (TickW+1)'(1);
  assign bits_dec = bits_left_q - BitCntW'(1);

  // Next state for one accepted item.
  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    bits_left_d = bits_left_q;
    bit_pos_d   = bit_pos_q;
    shift_d     = shift_q;
    is_read_d   = is_read_q;
    presence_d  = presence_q;
    done        = 1'b0;

    if (in_fire) begin
      if (in_item_i.action != owbm_pkg::ACT_TICK) begin
        // commands are dropped unless idle
        if (phase_q == owbm_pkg::PH_IDLE) begin
          tick_d    = '0;
          bit_pos_d = '0;
          unique case (in_item_i.action)
            owbm_pkg::ACT_RESET: begin
              is_read_d   = 1'b0;
              bits_left_d = '0;
              phase_d     = owbm_pkg::PH_RST_LOW;
            end
            owbm_pkg::ACT_WRITE: begin
              is_read_d   = 1'b0;
              bits_left_d = size_bits;
              shift_d     = in_item_i.write_data;
              phase_d     = owbm_pkg::PH_W_LOW;
            end
            default: begin
              is_read_d   = 1'b1;
              bits_left_d = size_bits;
              shift_d     = '0;
              phase_d     = owbm_pkg::PH_R_LOW;
            end
          endcase
        end
      end else if (phase_q != owbm_pkg::PH_IDLE) begin
        if (tick_inc < {1'b0, phase_len}) begin
          tick_d = tick_inc[TickW-1:0];
        end else begin
          tick_d = '0;
          unique case (phase_q)
            owbm_pkg::PH_RST_LOW:  phase_d = owbm_pkg::PH_RST_WAIT;
            owbm_pkg::PH_RST_WAIT: begin
              presence_d = in_item_i.line_level;
              phase_d    = owbm_pkg::PH_RST_SETTLE;
            end
            owbm_pkg::PH_RST_SETTLE: begin
              phase_d = owbm_pkg::PH_IDLE;
              done    = 1'b1;
            end
            owbm_pkg::PH_W_LOW:  phase_d = owbm_pkg::PH_W_DATA;
            owbm_pkg::PH_W_DATA: phase_d = owbm_pkg::PH_W_REC;
            owbm_pkg::PH_R_LOW:  phase_d = owbm_pkg::PH_R_WAIT;
            owbm_pkg::PH_R_WAIT: begin
              // positions past the word width are counted but not stored
              if (!bit_pos_q[BitCntW-1]) begin
                shift_d = shift_q |
                          ({{(WordW-1){1'b0}}, in_item_i.line_level} << bit_pos_q[4:0]);
              end
              phase_d = owbm_pkg::PH_R_REST;
            end
            owbm_pkg::PH_W_REC, owbm_pkg::PH_R_REST: begin
              // end of a bit slot
              if (!is_read_q) begin
                shift_d = shift_q >> 1;
              end
              bits_left_d = bits_dec;
              bit_pos_d   = bit_pos_q + BitCntW'(1);
              if (bits_dec == '0) begin
                phase_d = owbm_pkg::PH_IDLE;
                done    = 1'b1;
              end else begin
                phase_d = (phase_q == owbm_pkg::PH_W_REC) ? owbm_pkg::PH_W_LOW
                                                          : owbm_pkg::PH_R_LOW;
              end
            end
            default: phase_d = owbm_pkg::PH_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= owbm_pkg::PH_IDLE;
      tick_q      <= '0;
      bits_left_q <= '0;
      bit_pos_q   <= '0;
      shift_q     <= '0;
      is_read_q   <= 1'b0;
      presence_q  <= 1'b1;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      bits_left_q <= bits_left_d;
      bit_pos_q   <= bit_pos_d;
      shift_q     <= shift_d;
      is_read_q   <= is_read_d;
      presence_q  <= presence_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result item: describes the state after the item
  // --------------------------------------------------------------------------
  owbm_pkg::out_item_t res_d, res_q;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    unique case (phase_d)
      owbm_pkg::PH_RST_LOW,
      owbm_pkg::PH_W_LOW,
      owbm_pkg::PH_R_LOW:  res_d.drive_low = 1'b1;
      owbm_pkg::PH_W_DATA: res_d.drive_low = !shift_d[0];  // 1 bits release
      default:             res_d.drive_low = 1'b0;
    endcase
    res_d.busy_res       = (phase_d != owbm_pkg::PH_IDLE);
    res_d.done_res       = done;
    res_d.presence_level = presence_d;
    res_d.read_data      = (done && is_read_d) ? shift_d : '0;
  end

  // Output register: refills whenever it is empty or being taken.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign out_valid_d = in_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

endmodule

### hw/rtl/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker: port-level checks for the 1-Wire bus master
// Watches handshake and result consistency; attached by bind.
// ----------------------------------------------------------------------------
module owbm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input owbm_pkg::out_item_t out_item_o
);

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // a completing item leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res)
    else $error("done with busy still set");

  // read data only shows on a completing item
  a_data_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.read_data != '0) |-> out_item_o.done_res)
    else $error("read data outside a done item");

  // the line is only pulled while a command runs
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.drive_low |-> out_item_o.busy_res)
    else $error("line driven while idle");

  // an accepted item always yields a result next cycle
  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

endmodule

bind one_wire_bus_master_top owbm_checker u_owbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
